// File: rtl/core/wlm_pkg.sv
package wlm_pkg;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned GRAY_W  = 8;
  localparam int unsigned RECIP_W = 23;   // floor(2^24 / m) for m >= 3
  localparam int unsigned SPAN_W  = 17;   // hi - lo + 1, up to 65536
  localparam int unsigned DIV_STEPS = 25; // quotient bits of 2^24 / m
  localparam int unsigned STEP_W  = 5;

  localparam logic [GRAY_W-1:0] GRAY_ZERO = 8'd0;
  localparam logic [GRAY_W-1:0] GRAY_MID  = 8'd127;
  localparam logic [GRAY_W-1:0] GRAY_FULL = 8'd255;

  // configuration register indexes
  localparam logic [2:0] REG_IMG_LO  = 3'd0;
  localparam logic [2:0] REG_IMG_HI  = 3'd1;
  localparam logic [2:0] REG_MRK_LO  = 3'd2;
  localparam logic [2:0] REG_MRK_HI  = 3'd3;
  localparam logic [2:0] REG_INVERT  = 3'd4;
  localparam logic [2:0] REG_MODE    = 3'd5;
  localparam logic [2:0] REG_RAW     = 3'd6;

  localparam logic [1:0] MODE_IMG  = 2'd0;
  localparam logic [1:0] MODE_MRK  = 2'd1;
  localparam logic [1:0] MODE_DIFF = 2'd2;

  // window table entries
  localparam logic ENT_IMG = 1'b0;
  localparam logic ENT_MRK = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
  } win_bnd_t;

  typedef struct packed {
    logic [PIX_W-1:0]   lo;
    logic [PIX_W-1:0]   hi;
    logic [RECIP_W-1:0] recip;
  } win_ent_t;

endpackage

// File: rtl/core/window_level_display_map.sv
// Window/level mapper from 16-bit image and marker samples to an 8-bit display
// sample. One item is taken per clock while the input is not stalled; its result
// passes through the input register, reciprocal multiply, correction multiply and
// output register. A result waiting at the output holds the whole pipeline and so
// stalls the input.
// The per-window reciprocals live in a two-entry table filled by a bit-serial
// divider: after reset and after any write to a window bound the input stalls
// while the table is rebuilt, image entry first, marker entry second. Writes to
// the invert, mode and raw-byte registers take effect at once.
module window_level_display_map
  import wlm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  in_image_pixel,
  input  logic [PIX_W-1:0]  in_marker_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [GRAY_W-1:0] out_display_pixel,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [PIX_W-1:0]  cfg_data
);

  win_bnd_t   img_bnd_r;
  win_bnd_t   mrk_bnd_r;
  logic       invert_r;
  logic [1:0] mode_r;
  logic       raw_r;

  logic       busy;
  logic       win_wr;
  win_ent_t   img_ent;
  win_ent_t   mrk_ent;

  logic       en;
  logic       accept;
  logic       v1_r, v2_r, v3_r, out_valid_r;
  logic [PIX_W-1:0]  s1_img_r;
  logic [PIX_W-1:0]  s1_mrk_r;
  logic [GRAY_W-1:0] s2_raw_r;
  logic [GRAY_W-1:0] s3_raw_r;
  logic [GRAY_W-1:0] gi;
  logic [GRAY_W-1:0] gm_win;
  logic [GRAY_W-1:0] gm;
  logic [GRAY_W-1:0] res;
  logic [GRAY_W-1:0] out_pix_r;

  assign win_wr = cfg_we && (cfg_index == REG_IMG_LO || cfg_index == REG_IMG_HI ||
                             cfg_index == REG_MRK_LO || cfg_index == REG_MRK_HI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_bnd_r <= '{lo: '0, hi: '1};
      mrk_bnd_r <= '{lo: '0, hi: '1};
      invert_r  <= 1'b0;
      mode_r    <= MODE_IMG;
      raw_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMG_LO: img_bnd_r.lo <= cfg_data;
        REG_IMG_HI: img_bnd_r.hi <= cfg_data;
        REG_MRK_LO: mrk_bnd_r.lo <= cfg_data;
        REG_MRK_HI: mrk_bnd_r.hi <= cfg_data;
        REG_INVERT: invert_r     <= cfg_data[0];
        REG_MODE:   mode_r       <= cfg_data[1:0];
        REG_RAW:    raw_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  wlm_param u_param (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (win_wr),
    .img_bnd (img_bnd_r),
    .mrk_bnd (mrk_bnd_r),
    .busy    (busy),
    .img_ent (img_ent),
    .mrk_ent (mrk_ent)
  );

  // whole pipeline moves together whenever the output slot is free or being taken
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = busy || !en;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_img_r <= in_image_pixel;
      s1_mrk_r <= in_marker_pixel;
      s2_raw_r <= s1_mrk_r[GRAY_W-1:0];
      s3_raw_r <= s2_raw_r;
    end
  end

  wlm_lane u_img_lane (
    .clk  (clk),
    .en   (en),
    .pix  (s1_img_r),
    .ent  (img_ent),
    .gray (gi)
  );

  wlm_lane u_mrk_lane (
    .clk  (clk),
    .en   (en),
    .pix  (s1_mrk_r),
    .ent  (mrk_ent),
    .gray (gm_win)
  );

  assign gm = raw_r ? s3_raw_r : gm_win;

  always_comb begin
    case (mode_r)
      MODE_MRK:  res = gm;
      MODE_DIFF: res = (gm > gi) ? gm - gi : GRAY_ZERO;
      default:   res = invert_r ? GRAY_FULL - gi : gi;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_display_pixel = out_pix_r;

`ifndef SYNTHESIS
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !v1_r || $past(!en))
    else $error("item entered while window table was being rebuilt");

  a_item_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v3_r) |=> out_valid_r)
    else $error("item lost between last stage and output register");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v1_r) && $stable(v2_r) && $stable(v3_r) && $stable(out_pix_r))
    else $error("pipeline moved while output was stalled");
`endif

endmodule

// File: rtl/core/wlm_param.sv
module wlm_param
  import wlm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     restart,
  input  win_bnd_t img_bnd,
  input  win_bnd_t mrk_bnd,
  output logic     busy,
  output win_ent_t img_ent,
  output win_ent_t mrk_ent
);

  win_ent_t mem [2];
  win_ent_t img_rd_r;
  win_ent_t mrk_rd_r;

  logic               busy_r, busy_nxt;
  logic               ent_r, ent_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SPAN_W-1:0]  rem_r, rem_nxt;
  logic [RECIP_W-1:0] quo_r, quo_nxt;

  win_bnd_t           bnd;
  logic [SPAN_W-1:0]  m;
  logic [SPAN_W:0]    sh;
  logic               ge;
  logic [RECIP_W-1:0] quo_sh;
  logic               last_step;
  logic               fin;
  logic               we;
  win_ent_t           wdata;

  assign bnd = (ent_r == ENT_MRK) ? mrk_bnd : img_bnd;
  assign m   = {1'b0, bnd.hi} - {1'b0, bnd.lo} + SPAN_W'(1);

  // restoring division of 2^24 by m, one quotient bit a cycle
  assign sh        = {rem_r, (step_r == '0)};
  assign ge        = sh >= {1'b0, m};
  assign quo_sh    = {quo_r[RECIP_W-2:0], ge};
  assign last_step = step_r == STEP_W'(DIV_STEPS - 1);
  assign we        = busy_r && !restart && last_step;
  assign fin       = we && (ent_r == ENT_MRK);
  assign wdata     = '{lo: bnd.lo, hi: bnd.hi, recip: quo_sh};

  always_comb begin
    rem_nxt  = ge ? SPAN_W'(sh - {1'b0, m}) : SPAN_W'(sh);
    quo_nxt  = quo_sh;
    busy_nxt = busy_r;
    ent_nxt  = ent_r;
    step_nxt = step_r + STEP_W'(1);
    if (restart) begin
      busy_nxt = 1'b1;
      ent_nxt  = ENT_IMG;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (!busy_r) begin
      step_nxt = step_r;
      rem_nxt  = rem_r;
      quo_nxt  = quo_r;
    end else if (last_step) begin
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = '0;
      if (ent_r == ENT_MRK) begin
        busy_nxt = 1'b0;
      end else begin
        ent_nxt = ENT_MRK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      ent_r  <= ENT_IMG;
      step_r <= '0;
      rem_r  <= '0;
      quo_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ent_r  <= ent_nxt;
      step_r <= step_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[ent_r] <= wdata;
    end
    img_rd_r <= mem[ENT_IMG];
    mrk_rd_r <= mem[ENT_MRK];
  end

  assign busy    = busy_r;
  assign img_ent = img_rd_r;
  assign mrk_ent = mrk_rd_r;

`ifndef SYNTHESIS
  a_busy_ends_on_last_write: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(fin))
    else $error("table update finished without writing the marker entry");

  a_restart_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> busy_r && step_r == '0 && ent_r == ENT_IMG)
    else $error("window write did not restart the table update");
`endif

endmodule

// File: rtl/core/wlm_lane.sv
module wlm_lane
  import wlm_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [PIX_W-1:0]  pix,
  input  win_ent_t          ent,
  output logic [GRAY_W-1:0] gray
);

  logic [PIX_W-1:0]        d;
  logic [PIX_W-1:0]        span;
  logic [PIX_W+RECIP_W-1:0] prod;
  logic                    fix;
  logic [GRAY_W-1:0]       fix_val;

  logic                    a_fix_r;
  logic [GRAY_W-1:0]       a_fix_val_r;
  logic [GRAY_W-1:0]       a_qe_r;
  logic [PIX_W-1:0]        a_d_r;
  logic [SPAN_W-1:0]       a_m_r;

  logic [GRAY_W+SPAN_W-1:0] pm;
  logic                    b_fix_r;
  logic [GRAY_W-1:0]       b_fix_val_r;
  logic [GRAY_W-1:0]       b_qe_r;
  logic [PIX_W-1:0]        b_d_r;
  logic [SPAN_W-1:0]       b_m_r;
  logic [GRAY_W+SPAN_W-1:0] b_pm_r;

  logic [GRAY_W+SPAN_W-1:0] num;
  logic                    up;

  assign d    = pix - ent.lo;
  assign span = ent.hi - ent.lo;
  assign prod = (PIX_W+RECIP_W)'(d) * (PIX_W+RECIP_W)'(ent.recip);

  always_comb begin
    fix     = 1'b1;
    fix_val = GRAY_ZERO;
    if (ent.lo >= ent.hi) begin
      fix_val = GRAY_MID;
    end else if (span == PIX_W'(1)) begin
      fix_val = (pix <= ent.lo) ? GRAY_ZERO : GRAY_FULL;
    end else if (pix < ent.lo) begin
      fix_val = GRAY_ZERO;
    end else if (pix > ent.hi) begin
      fix_val = GRAY_FULL;
    end else begin
      fix = 1'b0;
    end
  end

  // estimate from the reciprocal is the true quotient or one below it
  always_ff @(posedge clk) begin
    if (en) begin
      a_fix_r     <= fix;
      a_fix_val_r <= fix_val;
      a_qe_r      <= prod[GRAY_W+15:16];
      a_d_r       <= d;
      a_m_r       <= {1'b0, span} + SPAN_W'(1);
    end
  end

  assign pm = (GRAY_W+SPAN_W)'(a_qe_r) * (GRAY_W+SPAN_W)'(a_m_r);

  always_ff @(posedge clk) begin
    if (en) begin
      b_fix_r     <= a_fix_r;
      b_fix_val_r <= a_fix_val_r;
      b_qe_r      <= a_qe_r;
      b_d_r       <= a_d_r;
      b_m_r       <= a_m_r;
      b_pm_r      <= pm;
    end
  end

  assign num  = {1'b0, b_d_r, 8'h00};
  assign up   = num >= (b_pm_r + (GRAY_W+SPAN_W)'(b_m_r));
  assign gray = b_fix_r ? b_fix_val_r : (up ? b_qe_r + GRAY_W'(1) : b_qe_r);

endmodule
